// ----- rtl/core/efc_pkg.sv -----
// ----------------------------------------------------------------------------
// Ethernet frame classifier package
// Shared constants, header offsets, host patterns and the result record.
// ----------------------------------------------------------------------------
package efc_pkg;

  localparam int unsigned MAX_FRAME_BYTES_DEF = 2048;
  localparam int unsigned PATTERN_BYTES_DEF   = 16;

  localparam logic [15:0] TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] TYPE_ARP  = 16'h0806;
  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [15:0] WEB_PORT  = 16'd80;
  localparam logic [15:0] ARP_REPLY = 16'd2;

  localparam logic [7:0] FLAG_SYN = 8'h02;
  localparam logic [7:0] FLAG_ACK = 8'h10;

  localparam int unsigned POS_TYPE_HI  = 12;
  localparam int unsigned POS_TYPE_LO  = 13;
  localparam int unsigned POS_IHL      = 14;
  localparam int unsigned POS_ARP_HI   = 20;
  localparam int unsigned POS_ARP_LO   = 21;
  localparam int unsigned POS_PROTO    = 23;
  localparam int unsigned POS_SRC_LO   = 26;
  localparam int unsigned POS_SRC_HI   = 29;
  localparam int unsigned TCP_BASE     = 14;

  localparam int unsigned TCP_DPORT_HI = 2;
  localparam int unsigned TCP_DPORT_LO = 3;
  localparam int unsigned TCP_DOFF     = 12;
  localparam int unsigned TCP_FLAGS    = 13;

  // bytes that can lie between payload start and the data offset byte
  localparam int unsigned LOOKBACK = 12;

  // host patterns, last character in the low byte
  localparam int unsigned HOST_A_LEN = 16;
  localparam int unsigned HOST_B_LEN = 13;
  localparam logic [8*HOST_A_LEN-1:0] HOST_A = 128'h7777772e676f6f676c652e636f2e756b;
  localparam logic [8*HOST_B_LEN-1:0] HOST_B = 104'h7777772e6262632e636f2e756b;

  typedef enum logic [1:0] {
    BLK_NONE   = 2'd0,
    BLK_FIRST  = 2'd1,
    BLK_SECOND = 2'd2
  } blocked_e;

  typedef struct packed {
    logic        arp_reply;
    blocked_e    blocked_host;
    logic [31:0] source_address;
    logic        syn_without_ack;
  } efc_result_t;

endpackage

// ----- rtl/core/efc_parse.sv -----
// ----------------------------------------------------------------------------
// Ethernet frame classifier parse stage
// Per-byte header capture, payload window and host match; result on last byte.
// ----------------------------------------------------------------------------
module efc_parse #(
  parameter int unsigned MAX_FRAME_BYTES = efc_pkg::MAX_FRAME_BYTES_DEF,
  parameter int unsigned PATTERN_BYTES   = efc_pkg::PATTERN_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  output efc_pkg::efc_result_t res_o
);

  localparam int unsigned PW  = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned WIN = PATTERN_BYTES - 1;

  logic [PW-1:0] pos_q, pos_d;
  logic [15:0]   ftype_q, ftype_d;
  logic [7:0]    proto_q, proto_d;
  logic [31:0]   src_q, src_d;
  logic [6:0]    tstart_q, tstart_d;
  logic [3:0]    doff_q, doff_d;
  logic [15:0]   dport_q, dport_d;
  logic [7:0]    flags_q, flags_d;
  logic [15:0]   arpop_q, arpop_d;
  logic [1:0]    hits_q, hits_d;
  logic          zero_q, zero_d;
  logic [7:0]    win_q [WIN];
  logic [7:0]    full_w [PATTERN_BYTES];

  logic          active;
  logic          tcp_zone;
  logic [PW-1:0] rel;
  logic [3:0]    doff_eff;
  logic [PW-1:0] ps_rel;
  logic          in_pay;
  logic          body;
  logic [3:0]    span;
  logic          lb_zero;
  logic          zprev;
  logic          eq_a, eq_b;
  logic          tcp, syn;

  assign full_w[0] = byte_i;
  for (genvar j = 1; j < PATTERN_BYTES; j++) begin : g_full
    assign full_w[j] = win_q[j-1];
  end

  if (efc_pkg::HOST_A_LEN <= PATTERN_BYTES) begin : g_cmp_a
    always_comb begin
      eq_a = 1'b1;
      for (int j = 0; j < efc_pkg::HOST_A_LEN; j++) begin
        if (full_w[j] != efc_pkg::HOST_A[8*j +: 8]) eq_a = 1'b0;
      end
    end
  end else begin : g_no_a
    assign eq_a = 1'b0;
  end

  if (efc_pkg::HOST_B_LEN <= PATTERN_BYTES) begin : g_cmp_b
    always_comb begin
      eq_b = 1'b1;
      for (int j = 0; j < efc_pkg::HOST_B_LEN; j++) begin
        if (full_w[j] != efc_pkg::HOST_B[8*j +: 8]) eq_b = 1'b0;
      end
    end
  end else begin : g_no_b
    assign eq_b = 1'b0;
  end

  assign active   = pos_q < PW'(MAX_FRAME_BYTES);
  assign rel      = pos_q - PW'(tstart_q);
  assign tcp_zone = (pos_q > PW'(efc_pkg::POS_IHL)) && (pos_q >= PW'(tstart_q));
  assign doff_eff = (rel == PW'(efc_pkg::TCP_DOFF)) ? byte_i[7:4] : doff_q;
  assign ps_rel   = PW'({doff_eff, 2'b00});
  assign in_pay   = tcp_zone && (rel >= ps_rel);
  assign body     = tcp_zone && (rel >= PW'(efc_pkg::TCP_DOFF));
  assign span     = 4'(efc_pkg::LOOKBACK) - {doff_eff[1:0], 2'b00};

  always_comb begin
    lb_zero = 1'b0;
    for (int k = 1; k <= efc_pkg::LOOKBACK; k++) begin
      if ((doff_eff[3:2] == 2'b00) && (4'(k) <= span) && (win_q[k-1] == 8'h00)) begin
        lb_zero = 1'b1;
      end
    end
  end

  assign zprev = (rel == PW'(efc_pkg::TCP_DOFF)) ? lb_zero : zero_q;

  always_comb begin
    pos_d    = pos_q;
    ftype_d  = ftype_q;
    proto_d  = proto_q;
    src_d    = src_q;
    tstart_d = tstart_q;
    doff_d   = doff_q;
    dport_d  = dport_q;
    flags_d  = flags_q;
    arpop_d  = arpop_q;
    hits_d   = hits_q;
    zero_d   = zero_q;
    if (active) begin
      pos_d = pos_q + PW'(1);
      if (pos_q == PW'(efc_pkg::POS_TYPE_HI)) ftype_d = {byte_i, 8'h00};
      if (pos_q == PW'(efc_pkg::POS_TYPE_LO)) ftype_d = {ftype_q[15:8], byte_i};
      if (pos_q == PW'(efc_pkg::POS_IHL)) begin
        tstart_d = 7'(efc_pkg::TCP_BASE) + {1'b0, byte_i[3:0], 2'b00};
      end
      if (pos_q == PW'(efc_pkg::POS_ARP_HI)) arpop_d = {byte_i, 8'h00};
      if (pos_q == PW'(efc_pkg::POS_ARP_LO)) arpop_d = {arpop_q[15:8], byte_i};
      if (pos_q == PW'(efc_pkg::POS_PROTO))  proto_d = byte_i;
      if ((pos_q >= PW'(efc_pkg::POS_SRC_LO)) && (pos_q <= PW'(efc_pkg::POS_SRC_HI))) begin
        src_d = {src_q[23:0], byte_i};
      end
      if (tcp_zone) begin
        if (rel == PW'(efc_pkg::TCP_DPORT_HI)) dport_d = {byte_i, 8'h00};
        if (rel == PW'(efc_pkg::TCP_DPORT_LO)) dport_d = {dport_q[15:8], byte_i};
        if (rel == PW'(efc_pkg::TCP_DOFF))     doff_d  = byte_i[7:4];
        if (rel == PW'(efc_pkg::TCP_FLAGS))    flags_d = byte_i;
      end
      if (body) begin
        if (!zprev && eq_a && (rel >= ps_rel + PW'(efc_pkg::HOST_A_LEN - 1))) hits_d[0] = 1'b1;
        if (!zprev && eq_b && (rel >= ps_rel + PW'(efc_pkg::HOST_B_LEN - 1))) hits_d[1] = 1'b1;
        zero_d = zprev || (in_pay && (byte_i == 8'h00));
      end
    end
  end

  assign tcp = (ftype_d == efc_pkg::TYPE_IPV4) && (proto_d == efc_pkg::PROTO_TCP);
  assign syn = tcp && ((flags_d & efc_pkg::FLAG_SYN) != 8'h00)
                   && ((flags_d & efc_pkg::FLAG_ACK) == 8'h00);

  always_comb begin
    res_o.syn_without_ack = syn;
    res_o.source_address  = syn ? src_d : 32'h0;
    res_o.blocked_host    = efc_pkg::BLK_NONE;
    if (tcp && (dport_d == efc_pkg::WEB_PORT)) begin
      if (hits_d[0]) begin
        res_o.blocked_host = efc_pkg::BLK_FIRST;
      end else if (hits_d[1]) begin
        res_o.blocked_host = efc_pkg::BLK_SECOND;
      end
    end
    res_o.arp_reply = (ftype_d == efc_pkg::TYPE_ARP) && (arpop_d == efc_pkg::ARP_REPLY);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      ftype_q  <= '0;
      proto_q  <= '0;
      src_q    <= '0;
      tstart_q <= '0;
      doff_q   <= '0;
      dport_q  <= '0;
      flags_q  <= '0;
      arpop_q  <= '0;
      hits_q   <= '0;
      zero_q   <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        pos_q    <= '0;
        ftype_q  <= '0;
        proto_q  <= '0;
        src_q    <= '0;
        tstart_q <= '0;
        doff_q   <= '0;
        dport_q  <= '0;
        flags_q  <= '0;
        arpop_q  <= '0;
        hits_q   <= '0;
        zero_q   <= 1'b0;
      end else begin
        pos_q    <= pos_d;
        ftype_q  <= ftype_d;
        proto_q  <= proto_d;
        src_q    <= src_d;
        tstart_q <= tstart_d;
        doff_q   <= doff_d;
        dport_q  <= dport_d;
        flags_q  <= flags_d;
        arpop_q  <= arpop_d;
        hits_q   <= hits_d;
        zero_q   <= zero_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && active) begin
      win_q[0] <= byte_i;
      for (int j = 1; j < WIN; j++) begin
        win_q[j] <= win_q[j-1];
      end
    end
  end

endmodule

// ----- rtl/core/ethernet_frame_classifier.sv -----
// ----------------------------------------------------------------------------
// Ethernet frame classifier
// Parses a byte stream of Ethernet frames and reports one verdict per frame.
// ----------------------------------------------------------------------------
//  channel   dir  request                    tdata bits (low first)
//  s_axis    in   one frame byte             [7:0] frame_byte; tlast frame_last
//  m_axis    out  one verdict per frame      [0] syn_without_ack,
//                                            [32:1] source_address,
//                                            [34:33] blocked_host,
//                                            [35] arp_reply, [39:36] zero
//
//  One byte a cycle sustained while no verdict is held; a byte passes the
//  input register, then the parse stage, and the verdict for a last byte
//  is then registered in the output register once the parse stage takes it.
//  Reset clears frame state and both valid flags; no clearing pass.
//  A held verdict stalls only a last byte; other bytes keep flowing.
// ----------------------------------------------------------------------------
module ethernet_frame_classifier #(
  parameter int unsigned MAX_FRAME_BYTES = efc_pkg::MAX_FRAME_BYTES_DEF,
  parameter int unsigned PATTERN_BYTES   = efc_pkg::PATTERN_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] frame_byte
  input  logic        s_axis_tlast,   // frame_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // syn_without_ack, source_address,
                                      // blocked_host, arp_reply, zero pad
);

  logic                 in_vld_q;
  logic [7:0]           in_byte_q;
  logic                 in_last_q;
  logic                 out_vld_q;
  efc_pkg::efc_result_t out_q;
  efc_pkg::efc_result_t res;
  logic                 out_free;
  logic                 adv;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign adv           = in_vld_q && (!in_last_q || out_free);
  assign s_axis_tready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  efc_parse #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
    .PATTERN_BYTES  (PATTERN_BYTES)
  ) u_parse (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(adv),
    .byte_i(in_byte_q),
    .last_i(in_last_q),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= adv && in_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && adv && in_last_q) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'h0, out_q};

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !adv |=> in_vld_q && $stable(in_byte_q) && $stable(in_last_q))
    else $error("input register lost a held byte");

  a_src_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_q.syn_without_ack |-> out_q.source_address == 32'h0)
    else $error("source address set without syn flag");

  a_arp_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.arp_reply |->
      !out_q.syn_without_ack && out_q.blocked_host == efc_pkg::BLK_NONE)
    else $error("arp verdict mixed with tcp verdict");

  a_last_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && !in_last_q && out_free |=> !out_vld_q)
    else $error("verdict raised on a byte that is not last");

endmodule

// ----- verif/frame_verdict_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame verdict checker
// Watches both streams of the classifier and parses each accepted frame byte
// with its own header and host-name scanner. It queues one verdict per frame
// end and compares every returned verdict with the oldest one in the queue.
// ----------------------------------------------------------------------------
module frame_verdict_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] frame_byte
  input  logic        s_axis_tlast,   // frame_last
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,   // syn_without_ack, source_address,
                                      // blocked_host, arp_reply, zero pad
  output int          errors_o,
  output int          pending_o
);

  int unsigned byte_pos;
  int unsigned tcp_start;
  logic [15:0] eth_type;
  logic [15:0] arp_op;
  logic [15:0] dst_port;
  logic [7:0]  ip_proto;
  logic [7:0]  tcp_flags;
  logic [3:0]  doff_words;
  logic [31:0] src_addr;
  logic [7:0]  window [efc_pkg::PATTERN_BYTES_DEF];
  logic [1:0]  host_hits;
  bit          zero_seen;

  efc_pkg::efc_result_t verdict_q[$];
  efc_pkg::efc_result_t want;
  efc_pkg::efc_result_t got;
  int          errors;
  int          verdicts_seen;

  function automatic void clear_frame();
    int i;
    byte_pos   = 0;
    tcp_start  = 0;
    eth_type   = '0;
    arp_op     = '0;
    dst_port   = '0;
    ip_proto   = '0;
    tcp_flags  = '0;
    doff_words = '0;
    src_addr   = '0;
    host_hits  = '0;
    zero_seen  = 1'b0;
    for (i = 0; i < efc_pkg::PATTERN_BYTES_DEF; i++) window[i] = '0;
  endfunction

  // window[0] is the newest byte; the pattern keeps its last character low
  function automatic bit host_ends_here(logic [8*efc_pkg::HOST_A_LEN-1:0] pat,
                                        int unsigned len);
    int unsigned k;
    if (len > efc_pkg::PATTERN_BYTES_DEF || len == 0) return 1'b0;
    for (k = 0; k < len; k++) begin
      if (window[k] !== pat[8*k +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void parse_frame_byte(logic [7:0] b);
    int unsigned p;
    int unsigned ps;
    int unsigned q;
    int i;
    bit zprev;
    if (byte_pos >= efc_pkg::MAX_FRAME_BYTES_DEF) return;
    p = byte_pos;
    byte_pos++;
    for (i = efc_pkg::PATTERN_BYTES_DEF - 1; i > 0; i--) window[i] = window[i-1];
    window[0] = b;

    if (p == efc_pkg::POS_TYPE_HI) eth_type = {b, 8'h00};
    if (p == efc_pkg::POS_TYPE_LO) eth_type = eth_type | b;
    if (p == efc_pkg::POS_IHL) tcp_start = efc_pkg::TCP_BASE + 4 * b[3:0];
    if (p == efc_pkg::POS_ARP_HI) arp_op = {b, 8'h00};
    if (p == efc_pkg::POS_ARP_LO) arp_op = arp_op | b;
    if (p == efc_pkg::POS_PROTO) ip_proto = b;
    if (p >= efc_pkg::POS_SRC_LO && p <= efc_pkg::POS_SRC_HI) begin
      src_addr = {src_addr[23:0], b};
    end
    if (p <= efc_pkg::POS_IHL) return;

    if (p == tcp_start + efc_pkg::TCP_DPORT_HI) dst_port = {b, 8'h00};
    if (p == tcp_start + efc_pkg::TCP_DPORT_LO) dst_port = dst_port | b;
    if (p == tcp_start + efc_pkg::TCP_DOFF) doff_words = b[7:4];
    if (p == tcp_start + efc_pkg::TCP_FLAGS) tcp_flags = b;
    if (p < tcp_start + efc_pkg::TCP_DOFF) return;

    ps = tcp_start + 4 * doff_words;
    if (p == tcp_start + efc_pkg::TCP_DOFF) begin
      // payload start only now known: look back for a zero already inside it
      zprev = 1'b0;
      for (q = ps; q < p; q++) begin
        if (p - q < efc_pkg::PATTERN_BYTES_DEF && window[p-q] == 8'h00) zprev = 1'b1;
      end
    end else begin
      zprev = zero_seen;
    end

    if (!zprev && p >= ps) begin
      if (p + 1 >= ps + efc_pkg::HOST_A_LEN &&
          host_ends_here(efc_pkg::HOST_A, efc_pkg::HOST_A_LEN)) host_hits[0] = 1'b1;
      if (p + 1 >= ps + efc_pkg::HOST_B_LEN &&
          host_ends_here(efc_pkg::HOST_B, efc_pkg::HOST_B_LEN)) host_hits[1] = 1'b1;
    end
    zero_seen = zprev || (p >= ps && b == 8'h00);
  endfunction

  function automatic efc_pkg::efc_result_t frame_verdict();
    efc_pkg::efc_result_t v;
    bit tcp;
    bit syn;
    tcp = eth_type == efc_pkg::TYPE_IPV4 && ip_proto == efc_pkg::PROTO_TCP;
    syn = tcp && (tcp_flags & efc_pkg::FLAG_SYN) != 0 && (tcp_flags & efc_pkg::FLAG_ACK) == 0;
    v.syn_without_ack = syn;
    v.source_address  = syn ? src_addr : 32'h0;
    v.blocked_host    = efc_pkg::BLK_NONE;
    if (tcp && dst_port == efc_pkg::WEB_PORT) begin
      if (host_hits[0]) v.blocked_host = efc_pkg::BLK_FIRST;
      else if (host_hits[1]) v.blocked_host = efc_pkg::BLK_SECOND;
    end
    v.arp_reply = eth_type == efc_pkg::TYPE_ARP && arp_op == efc_pkg::ARP_REPLY;
    return v;
  endfunction

  function automatic void report_wrong(string msg);
    errors++;
    if (errors <= 10) $display("%t: %s", $realtime, msg);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_frame();
      verdict_q.delete();
      errors        = 0;
      verdicts_seen = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        parse_frame_byte(s_axis_tdata);
        if (s_axis_tlast) begin
          verdict_q.push_back(frame_verdict());
          clear_frame();
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        verdicts_seen++;
        got = efc_pkg::efc_result_t'(m_axis_tdata[35:0]);
        if (verdict_q.size() == 0) begin
          report_wrong($sformatf("verdict %0d arrived with no frame end pending: %h",
                                 verdicts_seen, m_axis_tdata));
        end else begin
          want = verdict_q.pop_front();
          if (got.syn_without_ack !== want.syn_without_ack ||
              got.source_address !== want.source_address ||
              got.blocked_host !== want.blocked_host ||
              got.arp_reply !== want.arp_reply ||
              m_axis_tdata[39:36] !== 4'h0) begin
            report_wrong($sformatf({"verdict %0d wrong: expected syn %0b src %h host %0d ",
                                    "arp %0b, got syn %0b src %h host %0d arp %0b pad %h"},
                                   verdicts_seen, want.syn_without_ack,
                                   want.source_address, want.blocked_host, want.arp_reply,
                                   got.syn_without_ack, got.source_address,
                                   got.blocked_host, got.arp_reply, m_axis_tdata[39:36]));
          end
        end
      end
    end
    errors_o  <= errors;
    pending_o <= verdict_q.size();
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ethernet frame classifier testbench
// Sends directed frames (host names at payload edges, zero bytes, short,
// overlapping and oversized headers, ARP opcodes) and then random frames,
// with random gaps on both streams, a gap-free stretch and one long output
// hold-off. The checker beside the block predicts and compares verdicts.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tready = 1'b0;
  wire         s_axis_tready;
  wire         m_axis_tvalid;
  wire  [39:0] m_axis_tdata;

  int          errors;
  int          pending;
  bit          calm = 1'b0;
  bit          squeeze = 1'b0;
  int unsigned hold_left = 400;
  int unsigned cycles = 0;
  int unsigned bytes_sent = 0;
  int unsigned frames_sent = 0;
  logic [7:0]  frame_q[$];
  int          payload_at;

  ethernet_frame_classifier uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  frame_verdict_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .errors_o      (errors),
    .pending_o     (pending)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("ethernet_frame_classifier: mismatch");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (squeeze && hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 22);
    end
  end

  task automatic new_frame(int unsigned len);
    frame_q.delete();
    repeat (len) frame_q.push_back(8'($urandom_range(255, 1)));
  endtask

  task automatic put(int pos, logic [7:0] b);
    if (pos >= 0 && pos < frame_q.size()) frame_q[pos] = b;
  endtask

  task automatic cut_frame(int unsigned n);
    while (frame_q.size() > n) void'(frame_q.pop_back());
  endtask

  task automatic tcp_frame(logic [3:0] ihl, logic [3:0] doff, logic [7:0] proto,
                           logic [31:0] src, logic [15:0] dport, logic [7:0] flags,
                           int unsigned plen);
    int t;
    int i;
    t = efc_pkg::TCP_BASE + 4 * ihl;
    payload_at = t + 4 * doff;
    new_frame(payload_at + plen);
    put(efc_pkg::POS_TYPE_HI, efc_pkg::TYPE_IPV4[15:8]);
    put(efc_pkg::POS_TYPE_LO, efc_pkg::TYPE_IPV4[7:0]);
    put(efc_pkg::POS_IHL, {4'h4, ihl});
    put(efc_pkg::POS_PROTO, proto);
    for (i = 0; i < 4; i++) put(efc_pkg::POS_SRC_LO + i, src[31-8*i -: 8]);
    put(t + efc_pkg::TCP_DPORT_HI, dport[15:8]);
    put(t + efc_pkg::TCP_DPORT_LO, dport[7:0]);
    put(t + efc_pkg::TCP_DOFF, {doff, 4'($urandom)});
    put(t + efc_pkg::TCP_FLAGS, flags);
  endtask

  task automatic arp_frame(logic [15:0] op, int unsigned len);
    new_frame(len);
    put(efc_pkg::POS_TYPE_HI, efc_pkg::TYPE_ARP[15:8]);
    put(efc_pkg::POS_TYPE_LO, efc_pkg::TYPE_ARP[7:0]);
    put(efc_pkg::POS_ARP_HI, op[15:8]);
    put(efc_pkg::POS_ARP_LO, op[7:0]);
  endtask

  task automatic put_host(int pos, efc_pkg::blocked_e which);
    int i;
    if (which == efc_pkg::BLK_FIRST) begin
      for (i = 0; i < efc_pkg::HOST_A_LEN; i++) begin
        put(pos + i, efc_pkg::HOST_A[8*(efc_pkg::HOST_A_LEN-1-i) +: 8]);
      end
    end else begin
      for (i = 0; i < efc_pkg::HOST_B_LEN; i++) begin
        put(pos + i, efc_pkg::HOST_B[8*(efc_pkg::HOST_B_LEN-1-i) +: 8]);
      end
    end
  endtask

  task automatic send_byte(logic [7:0] b, bit last);
    while (!calm && $urandom_range(99) < 22) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_frame();
    int i;
    for (i = 0; i < frame_q.size(); i++) send_byte(frame_q[i], i == frame_q.size() - 1);
    frames_sent++;
  endtask

  task automatic random_frame(bit tiny);
    int unsigned r;
    int unsigned plen;
    logic [7:0] flags;
    r = $urandom_range(99);
    if (tiny) begin
      new_frame($urandom_range(3, 1));
      foreach (frame_q[i]) frame_q[i] = 8'($urandom);
    end else if (r < 60) begin
      plen  = $urandom_range(40);
      flags = $urandom_range(1) ? (efc_pkg::FLAG_SYN | (8'($urandom) & ~efc_pkg::FLAG_ACK))
                                : 8'($urandom);
      tcp_frame($urandom_range(3) == 0 ? 4'($urandom) : 4'd5,
                $urandom_range(3) == 0 ? 4'($urandom) : 4'd5,
                $urandom_range(9) == 0 ? 8'($urandom) : efc_pkg::PROTO_TCP,
                $urandom,
                $urandom_range(9) < 7 ? efc_pkg::WEB_PORT : 16'($urandom),
                flags, plen);
      case ($urandom_range(4))
        0: put_host(payload_at + $urandom_range(plen), efc_pkg::BLK_FIRST);
        1: put_host(payload_at + $urandom_range(plen), efc_pkg::BLK_SECOND);
        2: begin
          put_host(payload_at + $urandom_range(plen), efc_pkg::BLK_SECOND);
          put_host(payload_at + $urandom_range(plen), efc_pkg::BLK_FIRST);
        end
        3: put_host(payload_at - $urandom_range(6), efc_pkg::BLK_SECOND);
        default: ;
      endcase
      if ($urandom_range(3) == 0) put(payload_at + $urandom_range(plen), 8'h00);
      if ($urandom_range(9) == 0) cut_frame($urandom_range(frame_q.size(), 1));
    end else if (r < 78) begin
      arp_frame($urandom_range(2) == 0 ? 16'($urandom) : 16'($urandom_range(2, 1)),
                $urandom_range(64, 14));
      if ($urandom_range(9) == 0) cut_frame($urandom_range(frame_q.size(), 1));
    end else begin
      new_frame($urandom_range(70, 1));
      foreach (frame_q[i]) frame_q[i] = 8'($urandom);
    end
    send_frame();
  endtask

  initial begin
    int unsigned n;
    bit tiny;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // hosts in a SYN to port 80, both hosts, other port, other protocol
    tcp_frame(5, 5, efc_pkg::PROTO_TCP, 32'hC0A8_0001, efc_pkg::WEB_PORT,
              efc_pkg::FLAG_SYN, 24);
    put_host(payload_at + 3, efc_pkg::BLK_FIRST);
    send_frame();
    tcp_frame(5, 5, efc_pkg::PROTO_TCP, 32'hFFFF_FFFF, efc_pkg::WEB_PORT,
              efc_pkg::FLAG_SYN, 20);
    put_host(payload_at, efc_pkg::BLK_SECOND);
    send_frame();
    tcp_frame(5, 5, efc_pkg::PROTO_TCP, 32'h0000_0001, efc_pkg::WEB_PORT, 8'hFF, 40);
    put_host(payload_at, efc_pkg::BLK_SECOND);
    put_host(payload_at + 20, efc_pkg::BLK_FIRST);
    send_frame();
    tcp_frame(5, 5, efc_pkg::PROTO_TCP, $urandom, efc_pkg::WEB_PORT,
              efc_pkg::FLAG_SYN | efc_pkg::FLAG_ACK, 20);
    put_host(payload_at, efc_pkg::BLK_FIRST);
    send_frame();
    tcp_frame(5, 5, efc_pkg::PROTO_TCP, $urandom, efc_pkg::WEB_PORT + 16'd1,
              efc_pkg::FLAG_SYN, 20);
    put_host(payload_at, efc_pkg::BLK_FIRST);
    send_frame();
    tcp_frame(5, 5, 8'd17, $urandom, efc_pkg::WEB_PORT, efc_pkg::FLAG_SYN, 20);
    put_host(payload_at, efc_pkg::BLK_FIRST);
    send_frame();

    // zero byte ahead of and behind a host, host at and past frame end
    tcp_frame(5, 5, efc_pkg::PROTO_TCP, $urandom, efc_pkg::WEB_PORT, efc_pkg::FLAG_SYN, 30);
    put(payload_at + 2, 8'h00);
    put_host(payload_at + 5, efc_pkg::BLK_SECOND);
    send_frame();
    tcp_frame(5, 5, efc_pkg::PROTO_TCP, $urandom, efc_pkg::WEB_PORT, efc_pkg::FLAG_SYN, 30);
    put_host(payload_at, efc_pkg::BLK_SECOND);
    put(payload_at + efc_pkg::HOST_B_LEN, 8'h00);
    send_frame();
    tcp_frame(5, 5, efc_pkg::PROTO_TCP, $urandom, efc_pkg::WEB_PORT, efc_pkg::FLAG_SYN,
              efc_pkg::HOST_A_LEN);
    put_host(payload_at, efc_pkg::BLK_FIRST);
    send_frame();
    tcp_frame(5, 5, efc_pkg::PROTO_TCP, $urandom, efc_pkg::WEB_PORT, efc_pkg::FLAG_SYN,
              efc_pkg::HOST_B_LEN - 1);
    put_host(payload_at, efc_pkg::BLK_SECOND);
    send_frame();
    tcp_frame(5, 5, efc_pkg::PROTO_TCP, $urandom, efc_pkg::WEB_PORT, efc_pkg::FLAG_SYN, 20);
    put_host(payload_at - 3, efc_pkg::BLK_SECOND);
    send_frame();

    // payload starting before the data offset byte, with a zero in between, and maximal header lengths
    tcp_frame(5, 1, efc_pkg::PROTO_TCP, $urandom, efc_pkg::WEB_PORT, efc_pkg::FLAG_SYN, 30);
    put(payload_at + 2, 8'h00);
    put_host(payload_at + 12, efc_pkg::BLK_SECOND);
    send_frame();
    tcp_frame(0, 0, efc_pkg::PROTO_TCP, $urandom, efc_pkg::WEB_PORT, efc_pkg::FLAG_SYN, 40);
    put_host(payload_at + 20, efc_pkg::BLK_FIRST);
    send_frame();
    tcp_frame(15, 15, efc_pkg::PROTO_TCP, $urandom, efc_pkg::WEB_PORT, efc_pkg::FLAG_SYN, 20);
    put_host(payload_at + 2, efc_pkg::BLK_FIRST);
    send_frame();

    // ARP opcodes
    arp_frame(efc_pkg::ARP_REPLY, 42);
    send_frame();
    arp_frame(16'd1, 42);
    send_frame();
    arp_frame(16'h0202, 42);
    send_frame();

    // short frames
    new_frame(1);
    send_frame();
    arp_frame(efc_pkg::ARP_REPLY, 21);
    send_frame();
    tcp_frame(5, 5, efc_pkg::PROTO_TCP, $urandom, efc_pkg::WEB_PORT, efc_pkg::FLAG_SYN, 10);
    cut_frame(28);
    send_frame();
    tcp_frame(5, 5, efc_pkg::PROTO_TCP, $urandom, efc_pkg::WEB_PORT, efc_pkg::FLAG_SYN, 10);
    cut_frame(48);
    send_frame();

    // extreme byte values
    new_frame(64);
    foreach (frame_q[i]) frame_q[i] = 8'h00;
    send_frame();
    new_frame(64);
    foreach (frame_q[i]) frame_q[i] = 8'hFF;
    send_frame();

    n = 0;
    while (bytes_sent < 1500 || n < 18) begin
      tiny = n >= 6 && n < 18;
      calm    <= n < 6 || tiny;
      squeeze <= tiny;
      random_frame(tiny);
      n++;
    end
    s_axis_tvalid <= 1'b0;
    calm          <= 1'b0;
    squeeze       <= 1'b0;

    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("ethernet_frame_classifier: match");
    end else begin
      $display("ethernet_frame_classifier: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/efc_pkg.sv
rtl/core/efc_parse.sv
rtl/core/ethernet_frame_classifier.sv
verif/frame_verdict_checker.sv
verif/tb.sv
